// ----- rtl/cls_pkg.sv -----
// shared constants, types and helper functions of the chunk layout solver
`default_nettype none
package cls_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 16;

  // fixed field widths
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned CHUNK_W = 32;
  localparam int unsigned HDR_W = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CIDX_W = 4;
  localparam int unsigned CFG_IDX_W = 2;
  // exact layout position width
  localparam int unsigned POS_W = 56;
  localparam int unsigned PROD_W = SIZE_W + CHUNK_W;

  // opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  // result kinds
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_KEY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_COL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ROW_BIG = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ALIGN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd3;

  // reset values
  localparam logic [CHUNK_W-1:0] RST_CHUNK_BYTES = 32'd16384;
  localparam logic [SIZE_W-1:0] RST_KEY_SIZE = 16'd4;
  localparam logic [SIZE_W-1:0] RST_KEY_ALIGN = 16'd4;
  localparam logic [HDR_W-1:0] RST_HEADER_BYTES = 8'd16;

  typedef logic [POS_W-1:0] pos_t;

  // nonzero power of two
  function automatic logic is_pow2(input logic [SIZE_W-1:0] v);
    is_pow2 = (v != '0) && ((v & (v - SIZE_W'(1))) == '0);
  endfunction

  // round up to an alignment boundary, alignment zero or one leaves it
  function automatic pos_t align_up(input pos_t v, input logic [SIZE_W-1:0] a);
    pos_t m;
    m = POS_W'(a - SIZE_W'(1));
    if (a <= SIZE_W'(1)) align_up = v;
    else align_up = (v + m) & ~m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cls_if.sv -----
// request and result channel interfaces
`default_nettype none
interface cls_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [cls_pkg::SIZE_W-1:0] col_bytes;
  logic [cls_pkg::SIZE_W-1:0] column_alignment;
  modport source(output valid, opcode, col_bytes, column_alignment, input ready);
  modport sink(input valid, opcode, col_bytes, column_alignment, output ready);
endinterface

interface cls_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic [cls_pkg::STATUS_W-1:0] status;
  logic [cls_pkg::CHUNK_W-1:0] row_capacity;
  logic [cls_pkg::CHUNK_W-1:0] used_bytes;
  logic [cls_pkg::CHUNK_W-1:0] key_base;
  logic [cls_pkg::CHUNK_W-1:0] ver_base;
  logic [cls_pkg::CIDX_W-1:0] column_index;
  logic [cls_pkg::CHUNK_W-1:0] col_base;
  logic last;
  modport source(output valid, result_kind, status, row_capacity, used_bytes, key_base,
                 ver_base, column_index, col_base, last, input ready);
  modport sink(input valid, result_kind, status, row_capacity, used_bytes, key_base,
               ver_base, column_index, col_base, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/chunk_layout_solver_core.sv -----
// chunk layout solver: column table in memory, layout walker and row count search
// append request: accepted while idle, no result
// solve request: a layout walk is three key steps, align/mult then add per column, and
//   one decision step; check walk, then up to 32 search walks and a summary walk, each
//   after a search step, then an offset walk when columns are held
// one request at a time; a single output register carries results, stalls pause the walk
// synchronous active-low reset clears control state; column memory is not cleared
`default_nettype none
module chunk_layout_solver_core #(
  parameter int unsigned MAX_COLUMNS = cls_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cls_in_if.sink    in_if,
  cls_out_if.source out_if,
  input  wire logic cfg_we,
  input  wire logic [cls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cls_pkg::CHUNK_W-1:0]   cfg_wdata
);
  localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned SW = cls_pkg::SIZE_W;
  localparam int unsigned DW = cls_pkg::CHUNK_W;
  localparam int unsigned PW = cls_pkg::POS_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_COLUMNS);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY0 = 3'd1;
  localparam logic [2:0] S_KEY1 = 3'd2;
  localparam logic [2:0] S_KEY2 = 3'd3;
  localparam logic [2:0] S_CA = 3'd4;
  localparam logic [2:0] S_CB = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_DEC = 3'd7;

  // walk purposes
  localparam logic [1:0] M_CHECK = 2'd0;
  localparam logic [1:0] M_SEARCH = 2'd1;
  localparam logic [1:0] M_SUMMARY = 2'd2;
  localparam logic [1:0] M_COLS = 2'd3;

  // configuration registers
  logic [DW-1:0] chunk_r;
  logic [SW-1:0] key_size_r, key_al_r;
  logic [cls_pkg::HDR_W-1:0] hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= cls_pkg::RST_CHUNK_BYTES;
      key_size_r <= cls_pkg::RST_KEY_SIZE;
      key_al_r <= cls_pkg::RST_KEY_ALIGN;
      hdr_r <= cls_pkg::RST_HEADER_BYTES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cls_pkg::CFG_CHUNK_BYTES: chunk_r <= cfg_wdata;
        cls_pkg::CFG_KEY_SIZE: key_size_r <= cfg_wdata[SW-1:0];
        cls_pkg::CFG_KEY_ALIGN: key_al_r <= cfg_wdata[SW-1:0];
        cls_pkg::CFG_HEADER_BYTES: hdr_r <= cfg_wdata[cls_pkg::HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // state registers
  logic [2:0] st_r, st_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [CW-1:0] held_r, held_nxt, col_r, col_nxt;
  logic ovf_r, ovf_nxt, bad_r, bad_nxt;
  cls_pkg::pos_t pos_r, pos_nxt, key_off_r, key_off_nxt;
  logic [cls_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [DW-1:0] rows_r, rows_nxt, lo_r, lo_nxt, hi_r, hi_nxt;

  // output register
  logic ov_r, ov_nxt, okind_r, okind_nxt, olast_r, olast_nxt;
  logic [cls_pkg::STATUS_W-1:0] ostat_r, ostat_nxt;
  logic [DW-1:0] ocap_r, ocap_nxt, oused_r, oused_nxt, okey_r, okey_nxt;
  logic [DW-1:0] over_r, over_nxt, ocoff_r, ocoff_nxt;
  logic [cls_pkg::CIDX_W-1:0] ocidx_r, ocidx_nxt;

  // column memory: {alignment, size}
  logic ram_we;
  logic [2*SW-1:0] ram_rdata;
  logic [SW-1:0] cur_size, cur_al;

  assign ram_we = in_if.valid && in_if.ready && (in_if.opcode == cls_pkg::OP_APPEND)
                  && (held_r < MAX_CNT);
  assign cur_size = ram_rdata[SW-1:0];
  assign cur_al = ram_rdata[2*SW-1:SW];

  cls_ram #(.WIDTH(2 * SW), .DEPTH(MAX_COLUMNS)) u_col_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(held_r[AW-1:0]),
    .wdata({in_if.column_alignment, in_if.col_bytes}),
    .raddr(col_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // fixed layout pieces
  cls_pkg::pos_t ver_off, col_aligned;
  logic can_load;
  logic [DW:0] span;
  logic [DW-1:0] mid;
  logic [cls_pkg::STATUS_W-1:0] chk_stat;

  assign ver_off = (PW'(hdr_r) + PW'(7)) & ~PW'(7);
  assign col_aligned = cls_pkg::align_up(pos_r, cur_al);
  assign can_load = !ov_r || out_if.ready;
  assign span = ({1'b0, hi_r} - {1'b0, lo_r} + (DW + 1)'(1)) >> 1;
  assign mid = lo_r + span[DW-1:0];

  always_comb begin
    priority if (ovf_r) chk_stat = cls_pkg::ST_TOO_MANY;
    else if (key_size_r == '0 || !cls_pkg::is_pow2(key_al_r)) chk_stat = cls_pkg::ST_BAD_KEY;
    else if (bad_r) chk_stat = cls_pkg::ST_BAD_COL;
    else if (pos_r > PW'(chunk_r)) chk_stat = cls_pkg::ST_ROW_BIG;
    else chk_stat = cls_pkg::ST_OK;
  end

  assign in_if.ready = (st_r == S_IDLE);

  // sequencer
  always_comb begin
    st_nxt = st_r; mode_nxt = mode_r; held_nxt = held_r; col_nxt = col_r;
    ovf_nxt = ovf_r; bad_nxt = bad_r; pos_nxt = pos_r; key_off_nxt = key_off_r;
    prod_nxt = prod_r; rows_nxt = rows_r; lo_nxt = lo_r; hi_nxt = hi_r;
    ov_nxt = ov_r && !out_if.ready;
    okind_nxt = okind_r; olast_nxt = olast_r; ostat_nxt = ostat_r; ocap_nxt = ocap_r;
    oused_nxt = oused_r; okey_nxt = okey_r; over_nxt = over_r; ocoff_nxt = ocoff_r;
    ocidx_nxt = ocidx_r;
    unique case (st_r)
      S_IDLE: begin
        col_nxt = '0;
        if (in_if.valid) begin
          if (in_if.opcode == cls_pkg::OP_APPEND) begin
            if (held_r < MAX_CNT) held_nxt = held_r + CW'(1);
            else ovf_nxt = 1'b1;
          end else begin
            rows_nxt = DW'(1);
            mode_nxt = M_CHECK;
            bad_nxt = 1'b0;
            st_nxt = S_KEY0;
          end
        end
      end
      S_KEY0: begin
        col_nxt = '0;
        pos_nxt = ver_off + (PW'(held_r) << 3);
        st_nxt = S_KEY1;
      end
      S_KEY1: begin
        pos_nxt = cls_pkg::align_up(pos_r, key_al_r);
        key_off_nxt = cls_pkg::align_up(pos_r, key_al_r);
        prod_nxt = key_size_r * rows_r;
        st_nxt = S_KEY2;
      end
      S_KEY2: begin
        pos_nxt = pos_r + PW'(prod_r);
        st_nxt = (held_r == '0) ? S_DONE : S_CA;
      end
      S_CA: begin
        if (mode_r != M_COLS || can_load) begin
          pos_nxt = col_aligned;
          prod_nxt = cur_size * rows_r;
          col_nxt = col_r + CW'(1);
          if (cur_size == '0 || !cls_pkg::is_pow2(cur_al)) bad_nxt = 1'b1;
          if (mode_r == M_COLS) begin
            ov_nxt = 1'b1;
            okind_nxt = cls_pkg::KIND_COLUMN;
            ostat_nxt = cls_pkg::ST_OK;
            ocap_nxt = '0; oused_nxt = '0; okey_nxt = '0; over_nxt = '0;
            ocidx_nxt = cls_pkg::CIDX_W'(col_r);
            ocoff_nxt = col_aligned[DW-1:0];
            olast_nxt = (col_r + CW'(1) == held_r);
          end
          st_nxt = S_CB;
        end
      end
      S_CB: begin
        pos_nxt = pos_r + PW'(prod_r);
        st_nxt = (col_r == held_r) ? S_DONE : S_CA;
      end
      S_DONE: begin
        unique case (mode_r)
          M_CHECK: begin
            if (chk_stat != cls_pkg::ST_OK) begin
              if (can_load) begin
                ov_nxt = 1'b1;
                okind_nxt = cls_pkg::KIND_SUMMARY;
                ostat_nxt = chk_stat;
                ocap_nxt = '0; oused_nxt = '0; okey_nxt = '0; over_nxt = '0;
                ocidx_nxt = '0; ocoff_nxt = '0; olast_nxt = 1'b1;
                held_nxt = '0; ovf_nxt = 1'b0;
                st_nxt = S_IDLE;
              end
            end else begin
              lo_nxt = DW'(1);
              hi_nxt = chunk_r;
              st_nxt = S_DEC;
            end
          end
          M_SEARCH: begin
            if (pos_r <= PW'(chunk_r)) lo_nxt = rows_r;
            else hi_nxt = rows_r - DW'(1);
            st_nxt = S_DEC;
          end
          M_SUMMARY: begin
            if (can_load) begin
              ov_nxt = 1'b1;
              okind_nxt = cls_pkg::KIND_SUMMARY;
              ostat_nxt = cls_pkg::ST_OK;
              ocap_nxt = rows_r;
              oused_nxt = pos_r[DW-1:0];
              okey_nxt = key_off_r[DW-1:0];
              over_nxt = ver_off[DW-1:0];
              ocidx_nxt = '0; ocoff_nxt = '0;
              olast_nxt = (held_r == '0);
              if (held_r == '0) begin
                ovf_nxt = 1'b0;
                st_nxt = S_IDLE;
              end else begin
                mode_nxt = M_COLS;
                st_nxt = S_KEY0;
              end
            end
          end
          default: begin
            held_nxt = '0; ovf_nxt = 1'b0;
            st_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        // search step decision
        if (lo_r < hi_r) begin
          rows_nxt = mid;
          mode_nxt = M_SEARCH;
        end else begin
          rows_nxt = lo_r;
          mode_nxt = M_SUMMARY;
        end
        st_nxt = S_KEY0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      mode_r <= M_CHECK;
      held_r <= '0;
      col_r <= '0;
      ovf_r <= 1'b0;
      bad_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      col_r <= col_nxt;
      ovf_r <= ovf_nxt;
      bad_r <= bad_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; key_off_r <= key_off_nxt; prod_r <= prod_nxt;
    rows_r <= rows_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    okind_r <= okind_nxt; olast_r <= olast_nxt; ostat_r <= ostat_nxt;
    ocap_r <= ocap_nxt; oused_r <= oused_nxt; okey_r <= okey_nxt;
    over_r <= over_nxt; ocoff_r <= ocoff_nxt; ocidx_r <= ocidx_nxt;
  end

  // result channel
  assign out_if.valid = ov_r;
  assign out_if.result_kind = okind_r;
  assign out_if.status = ostat_r;
  assign out_if.row_capacity = ocap_r;
  assign out_if.used_bytes = oused_r;
  assign out_if.key_base = okey_r;
  assign out_if.ver_base = over_r;
  assign out_if.column_index = ocidx_r;
  assign out_if.col_base = ocoff_r;
  assign out_if.last = olast_r;
endmodule
`default_nettype wire

// ----- rtl/cls_ram.sv -----
// generic single write, single registered read memory
`default_nettype none
module cls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the chunk layout solver: directed table, random column sets, layout predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import cls_pkg::*;

  // one result as seen on the output channel
  typedef struct {
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic [CHUNK_W-1:0]  cap;
    logic [CHUNK_W-1:0]  used;
    logic [CHUNK_W-1:0]  koff;
    logic [CHUNK_W-1:0]  voff;
    logic [CIDX_W-1:0]   cidx;
    logic [CHUNK_W-1:0]  coff;
    logic                last;
  } layout_result_t;

  // directed request, optionally with a typed-in summary
  typedef struct {
    logic                op;
    logic [SIZE_W-1:0]   sz;
    logic [SIZE_W-1:0]   al;
    int                  reps;
    bit                  pinned;
    logic [STATUS_W-1:0] st;
    logic [CHUNK_W-1:0]  cap;
    logic [CHUNK_W-1:0]  used;
    logic [CHUNK_W-1:0]  koff;
    logic [CHUNK_W-1:0]  voff;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CHUNK_W-1:0] cfg_wdata;

  cls_in_if req_ch();
  cls_out_if res_ch();

  chunk_layout_solver_core u_top (
    .clk(clk), .rst_n(rst_n), .in_if(req_ch), .out_if(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [CHUNK_W-1:0] chunk_q;
  logic [SIZE_W-1:0] keysz_q;
  logic [SIZE_W-1:0] keyal_q;
  logic [HDR_W-1:0] hdr_q;
  logic [SIZE_W-1:0] col_size_m[MAX_COLUMNS_DEF];
  logic [SIZE_W-1:0] col_align_m[MAX_COLUMNS_DEF];
  int unsigned cols_held_m;
  bit cols_overflow_m;
  longint unsigned ver_off_m;
  longint unsigned key_off_m;
  longint unsigned col_off_m[MAX_COLUMNS_DEF];

  layout_result_t pending_results[$];
  int mismatches;
  int long_hold;
  bit burst;

  always #6 clk = ~clk;

  function automatic bit pow2(input logic [SIZE_W-1:0] v);
    return (v != 0) && ((v & (v - 16'd1)) == 0);
  endfunction

  function automatic longint unsigned align_pad(input longint unsigned v,
                                                input logic [SIZE_W-1:0] a);
    longint unsigned m;
    if (a <= 16'd1) return v;
    m = longint'(a) - 1;
    return (v + m) & ~m;
  endfunction

  // total bytes for a row count, offsets left in the predictor state
  function automatic longint unsigned place_rows(input longint unsigned rows);
    longint unsigned pos;
    ver_off_m = align_pad(longint'(hdr_q), 16'd8);
    pos = ver_off_m + longint'(cols_held_m) * 8;
    key_off_m = align_pad(pos, keyal_q);
    pos = key_off_m + longint'(keysz_q) * rows;
    for (int i = 0; i < cols_held_m; i++) begin
      pos = align_pad(pos, col_align_m[i]);
      col_off_m[i] = pos;
      pos = pos + longint'(col_size_m[i]) * rows;
    end
    return pos;
  endfunction

  // results caused by one accepted request
  function automatic void predict_request(input logic op, input logic [SIZE_W-1:0] sz,
                                          input logic [SIZE_W-1:0] al,
                                          ref layout_result_t res[$]);
    logic [STATUS_W-1:0] st;
    longint unsigned row_total, lo, hi, mid, total;
    layout_result_t r;
    res.delete();
    if (op == OP_APPEND) begin
      if (cols_held_m < MAX_COLUMNS_DEF) begin
        col_size_m[cols_held_m] = sz;
        col_align_m[cols_held_m] = al;
        cols_held_m++;
      end else begin
        cols_overflow_m = 1;
      end
      return;
    end
    st = ST_OK;
    if (cols_overflow_m) st = ST_TOO_MANY;
    else if (keysz_q == 0 || !pow2(keyal_q)) st = ST_BAD_KEY;
    else begin
      for (int i = 0; i < cols_held_m; i++)
        if (col_size_m[i] == 0 || !pow2(col_align_m[i])) st = ST_BAD_COL;
      if (st == ST_OK && place_rows(1) > longint'(chunk_q)) st = ST_ROW_BIG;
    end
    r = '{KIND_SUMMARY, st, 0, 0, 0, 0, 0, 0, 1'b1};
    if (st != ST_OK) begin
      res = {res, r};
    end else begin
      row_total = keysz_q;
      for (int i = 0; i < cols_held_m; i++) row_total += col_size_m[i];
      lo = 1;
      hi = longint'(chunk_q) / row_total + 1;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (place_rows(mid) <= longint'(chunk_q)) lo = mid;
        else hi = mid - 1;
      end
      total = place_rows(lo);
      r.cap = lo[31:0];
      r.used = total[31:0];
      r.koff = key_off_m[31:0];
      r.voff = ver_off_m[31:0];
      r.last = (cols_held_m == 0);
      res = {res, r};
      for (int i = 0; i < cols_held_m; i++) begin
        r = '{KIND_COLUMN, ST_OK, 0, 0, 0, 0, i[3:0], col_off_m[i][31:0],
              (i + 1 == cols_held_m)};
        res = {res, r};
      end
    end
    cols_held_m = 0;
    cols_overflow_m = 0;
  endfunction

  function automatic void check_field(input string name, input longint unsigned exp_v,
                                      input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    layout_result_t e;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: kind %0d status %0d", res_ch.result_kind,
               res_ch.status);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        check_field("result_kind", e.kind, res_ch.result_kind);
        check_field("status", e.status, res_ch.status);
        check_field("row_capacity", e.cap, res_ch.row_capacity);
        check_field("used_bytes", e.used, res_ch.used_bytes);
        check_field("key_base", e.koff, res_ch.key_base);
        check_field("ver_base", e.voff, res_ch.ver_base);
        check_field("column_index", e.cidx, res_ch.column_index);
        check_field("col_base", e.coff, res_ch.col_base);
        check_field("last", e.last, res_ch.last);
      end
    end
  end

  // result side: random stalls, one long hold-off when asked
  initial begin : result_sink
    int w;
    res_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        res_ch.ready <= 0;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
      end
      w = burst ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        res_ch.ready <= 0;
        repeat (w) @(negedge clk);
      end
      res_ch.ready <= 1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // offer one request, called at a falling edge, returns at a falling edge
  task automatic send_request(input logic op, input logic [SIZE_W-1:0] sz,
                              input logic [SIZE_W-1:0] al, input bit pinned,
                              input layout_result_t pin_r);
    int gap;
    layout_result_t res[$];
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.opcode <= op;
    req_ch.col_bytes <= sz;
    req_ch.column_alignment <= al;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(op, sz, al, res);
    if (pinned) res[0] = pin_r;
    foreach (res[i]) pending_results = {pending_results, res[i]};
    @(negedge clk);
  endtask

  // settle, then write all four registers
  task automatic apply_setting(input logic [31:0] cb, input logic [15:0] ks,
                               input logic [15:0] ka, input logic [7:0] hb);
    req_ch.valid <= 0;
    wait (pending_results.size() == 0);
    repeat (120) @(negedge clk);
    cfg_we <= 1; cfg_index <= CFG_CHUNK_BYTES; cfg_wdata <= cb;
    @(negedge clk);
    cfg_index <= CFG_KEY_SIZE; cfg_wdata <= 32'(ks);
    @(negedge clk);
    cfg_index <= CFG_KEY_ALIGN; cfg_wdata <= 32'(ka);
    @(negedge clk);
    cfg_index <= CFG_HEADER_BYTES; cfg_wdata <= 32'(hb);
    @(negedge clk);
    cfg_we <= 0;
    chunk_q = cb; keysz_q = ks; keyal_q = ka; hdr_q = hb;
  endtask

  // one random column descriptor, mostly well formed
  task automatic send_column();
    logic [SIZE_W-1:0] sz, al;
    int pick;
    layout_result_t none;
    none = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    pick = $urandom_range(0, 99);
    if (pick < 70) sz = SIZE_W'($urandom_range(1, 64));
    else if (pick < 95) sz = SIZE_W'($urandom_range(1, 65535));
    else sz = 0;
    pick = $urandom_range(0, 99);
    if (pick < 94) al = 16'd1 << $urandom_range(0, 15);
    else if (pick < 97) al = 0;
    else al = SIZE_W'($urandom);
    send_request(OP_APPEND, sz, al, 0, none);
  endtask

  directed_row_t plan[15] = '{
    '{OP_SOLVE, 0, 0, 1, 1, ST_OK, 4092, 16384, 16, 16},
    '{OP_APPEND, 16'd1, 16'd1, 1, 0, ST_OK, 0, 0, 0, 0},
    '{OP_APPEND, 16'hFFFF, 16'h8000, 1, 0, ST_OK, 0, 0, 0, 0},
    '{OP_SOLVE, 0, 0, 1, 1, ST_ROW_BIG, 0, 0, 0, 0},
    '{OP_APPEND, 16'd0, 16'd1, 1, 0, ST_OK, 0, 0, 0, 0},
    '{OP_SOLVE, 16'hFFFF, 16'hFFFF, 1, 1, ST_BAD_COL, 0, 0, 0, 0},
    '{OP_APPEND, 16'd5, 16'd0, 1, 0, ST_OK, 0, 0, 0, 0},
    '{OP_SOLVE, 0, 0, 1, 1, ST_BAD_COL, 0, 0, 0, 0},
    '{OP_APPEND, 16'd5, 16'hFFFF, 1, 0, ST_OK, 0, 0, 0, 0},
    '{OP_SOLVE, 0, 0, 1, 1, ST_BAD_COL, 0, 0, 0, 0},
    '{OP_APPEND, 16'd8, 16'd8, 17, 0, ST_OK, 0, 0, 0, 0},
    '{OP_SOLVE, 0, 0, 1, 1, ST_TOO_MANY, 0, 0, 0, 0},
    '{OP_APPEND, 16'd100, 16'd2, 1, 0, ST_OK, 0, 0, 0, 0},
    '{OP_APPEND, 16'h00FF, 16'h0010, 1, 0, ST_OK, 0, 0, 0, 0},
    '{OP_SOLVE, 0, 0, 1, 0, ST_OK, 0, 0, 0, 0}
  };

  // register settings per phase: chunk, key size, key alignment, header
  logic [31:0] set_chunk[7] = '{32'd16384, 32'hFFFFFFFF, 32'd0, 32'd4096,
                                 32'd65536, 32'd1000, 32'h0010_0000};
  logic [15:0] set_ksz[7] = '{16'd4, 16'hFFFF, 16'd1, 16'd0, 16'd8, 16'd2, 16'd4};
  logic [15:0] set_kal[7] = '{16'd4, 16'h8000, 16'd1, 16'd4, 16'd0, 16'd3, 16'd8};
  logic [7:0] set_hdr[7] = '{8'd16, 8'hFF, 8'd0, 8'd8, 8'd3, 8'hFF, 8'd24};

  // main sequence
  initial begin : stimulus
    layout_result_t pin_r;
    int sent, ncols;
    clk = 0;
    rst_n = 0;
    cfg_we = 0; cfg_index = CFG_CHUNK_BYTES; cfg_wdata = 0;
    req_ch.valid = 0; req_ch.opcode = OP_APPEND;
    req_ch.col_bytes = 0; req_ch.column_alignment = 0;
    mismatches = 0; long_hold = 0; burst = 0;
    chunk_q = RST_CHUNK_BYTES; keysz_q = RST_KEY_SIZE;
    keyal_q = RST_KEY_ALIGN; hdr_q = RST_HEADER_BYTES;
    cols_held_m = 0; cols_overflow_m = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed table under reset settings
    foreach (plan[i]) begin
      pin_r = '{KIND_SUMMARY, plan[i].st, plan[i].cap, plan[i].used, plan[i].koff,
                plan[i].voff, 0, 0, 1'b1};
      repeat (plan[i].reps)
        send_request(plan[i].op, plan[i].sz, plan[i].al, plan[i].pinned, pin_r);
    end

    // random column sets under each setting
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) apply_setting(set_chunk[ph], set_ksz[ph], set_kal[ph], set_hdr[ph]);
      burst = (ph == 3);
      if (ph == 1) long_hold = 400;
      sent = 0;
      while (sent < 22) begin
        if ($urandom_range(0, 9) == 0) ncols = $urandom_range(17, 20);
        else ncols = $urandom_range(0, 16);
        repeat (ncols) send_column();
        pin_r = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_request(OP_SOLVE, SIZE_W'($urandom), SIZE_W'($urandom), 0, pin_r);
        sent += ncols + 1;
      end
    end

    req_ch.valid <= 0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
